### hw/rtl/sha1sh_pkg.sv
package sha1sh_pkg;

    localparam int HASH_WORDS = 5;
    localparam int SCHED_WORDS = 16;
    localparam int ROUNDS = 80;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    typedef logic [HASH_WORDS-1:0][31:0] t_hash;

    localparam t_hash H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } t_phase;

    typedef struct packed {
        logic   init;
        logic   start;
        logic   round;
        logic   fold;
        t_phase phase;
    } t_core_cmd;

    typedef struct packed {
        logic       load;
        logic       shift;
        logic [7:0] data;
    } t_sched_cmd;

    function automatic logic [31:0] k_const(input t_phase ph);
        logic [31:0] k;
        case (ph)
            PH_CH:   k = 32'h5A827999;
            PH_PAR1: k = 32'h6ED9EBA1;
            PH_MAJ:  k = 32'h8F1BBCDC;
            PH_PAR2: k = 32'hCA62C1D6;
            default: k = 32'h5A827999;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] f_func(input t_phase ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (ph)
            PH_CH:   f = (b & c) | (~b & d);
            PH_MAJ:  f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

### hw/rtl/sha1sh_sched.sv
module sha1sh_sched
    import sha1sh_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_cmd  i_cmd,
    output logic [31:0] o_w0
);

    logic [31:0] r_w [SCHED_WORDS];
    logic [31:0] n_mix;
    logic [31:0] n_new;

    assign n_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign n_new = {n_mix[30:0], n_mix[31]};
    assign o_w0  = r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < SCHED_WORDS - 1; k++) begin
                r_w[k] <= {r_w[k][23:0], r_w[k+1][31:24]};
            end
            r_w[SCHED_WORDS-1] <= {r_w[SCHED_WORDS-1][23:0], i_cmd.data};
        end else if (i_cmd.shift) begin
            for (int k = 0; k < SCHED_WORDS - 1; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[SCHED_WORDS-1] <= n_new;
        end
    end

endmodule

### hw/rtl/sha1sh_core.sv
module sha1sh_core
    import sha1sh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_cmd   i_cmd,
    input  logic [31:0] i_w,
    output t_hash       o_hash
);

    t_hash       r_h;
    t_hash       r_work;
    logic [31:0] n_t;

    assign n_t = {r_work[0][26:0], r_work[0][31:27]}
               + f_func(i_cmd.phase, r_work[1], r_work[2], r_work[3])
               + r_work[4] + i_w + k_const(i_cmd.phase);

    assign o_hash = r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= H_INIT;
        end else if (i_cmd.init) begin
            r_h <= H_INIT;
        end else if (i_cmd.fold) begin
            for (int k = 0; k < HASH_WORDS; k++) begin
                r_h[k] <= r_h[k] + r_work[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_work <= r_h;
        end else if (i_cmd.round) begin
            r_work[4] <= r_work[3];
            r_work[3] <= r_work[2];
            r_work[2] <= {r_work[1][1:0], r_work[1][31:2]};
            r_work[1] <= r_work[0];
            r_work[0] <= n_t;
        end
    end

endmodule

### hw/rtl/sha1_stream_hasher.sv
// SHA-1 over a byte stream. The transfer that completes a 64-byte block is followed
// by 80 rounds on the single round unit and a fold into the chain words, during
// which no input is taken. A finish writes padding and then the length byte by
// byte, runs one or two such compressions, then offers the five digest words
// H0..H4, one per output transfer. The last output transfer restarts the block
// for a new message. After a length overflow the finish skips hashing and returns
// five zero words flagged with error.
module sha1_stream_hasher
    import sha1sh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_error
);

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_cnt, n_cnt;
    logic        r_ovf, n_ovf;
    logic [6:0]  r_step, n_step;
    logic [2:0]  r_widx, n_widx;
    logic        r_err, n_err;

    t_core_cmd   core_cmd;
    t_sched_cmd  sched_cmd;
    t_hash       hash;
    logic [31:0] w0;
    logic [63:0] len_shift;

    sha1sh_sched u_sched (
        .i_clk (i_clk),
        .i_cmd (sched_cmd),
        .o_w0  (w0)
    );

    sha1sh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (core_cmd),
        .i_w     (w0),
        .o_hash  (hash)
    );

    assign len_shift = {r_cnt, 3'b000} << {r_step[2:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_step  <= '0;
            r_widx  <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_step  <= n_step;
            r_widx  <= n_widx;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_step      = r_step;
        n_widx      = r_widx;
        n_err       = r_err;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        core_cmd    = '0;
        sched_cmd   = '0;
        if (r_step < 7'd20) begin
            core_cmd.phase = PH_CH;
        end else if (r_step < 7'd40) begin
            core_cmd.phase = PH_PAR1;
        end else if (r_step < 7'd60) begin
            core_cmd.phase = PH_MAJ;
        end else begin
            core_cmd.phase = PH_PAR2;
        end
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_action) begin
                        if (!r_ovf) begin
                            if (&r_cnt) begin
                                n_ovf = 1'b1;
                            end else begin
                                sched_cmd.load = 1'b1;
                                sched_cmd.data = i_data_byte;
                                n_cnt  = r_cnt + 61'd1;
                                n_fill = r_fill + 6'd1;
                                if (r_fill == LAST_POS) begin
                                    n_state        = ST_ROUND;
                                    n_ret          = ST_IDLE;
                                    n_step         = '0;
                                    core_cmd.start = 1'b1;
                                end
                            end
                        end
                    end else if (r_ovf) begin
                        n_state = ST_EMIT;
                        n_err   = 1'b1;
                        n_widx  = '0;
                    end else begin
                        sched_cmd.load = 1'b1;
                        sched_cmd.data = PAD_BYTE;
                        n_fill = r_fill + 6'd1;
                        if (r_fill == LAST_POS) begin
                            n_state        = ST_ROUND;
                            n_ret          = ST_PAD;
                            n_step         = '0;
                            core_cmd.start = 1'b1;
                        end else begin
                            n_state = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LEN_POS) begin
                    n_state = ST_LEN;
                    n_step  = '0;
                end else begin
                    sched_cmd.load = 1'b1;
                    sched_cmd.data = 8'h00;
                    n_fill = r_fill + 6'd1;
                    if (r_fill == LAST_POS) begin
                        n_state        = ST_ROUND;
                        n_ret          = ST_PAD;
                        n_step         = '0;
                        core_cmd.start = 1'b1;
                    end
                end
            end
            ST_LEN: begin
                sched_cmd.load = 1'b1;
                sched_cmd.data = len_shift[63:56];
                n_fill = r_fill + 6'd1;
                n_step = r_step + 7'd1;
                if (r_step[2:0] == 3'd7) begin
                    n_state        = ST_ROUND;
                    n_ret          = ST_EMIT;
                    n_step         = '0;
                    n_widx         = '0;
                    n_err          = 1'b0;
                    core_cmd.start = 1'b1;
                end
            end
            ST_ROUND: begin
                core_cmd.round  = 1'b1;
                sched_cmd.shift = 1'b1;
                n_step = r_step + 7'd1;
                if (r_step == 7'(ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                core_cmd.fold = 1'b1;
                n_state       = r_ret;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'(HASH_WORDS - 1)) begin
                        core_cmd.init = 1'b1;
                        n_state = ST_IDLE;
                        n_widx  = '0;
                        n_fill  = '0;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_err   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_digest_word = r_err ? 32'h0 : hash[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 3'(HASH_WORDS - 1));
    assign o_error       = r_err;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input and output sides active together");

    a_round_empty_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_fill == 6'd0))
        else $error("compression with a partial block");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_digest_word == 32'h0))
        else $error("error word not zero");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_word_index <= 3'(HASH_WORDS - 1)))
        else $error("word index out of range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=>
            (o_in_ready && r_fill == 6'd0 && r_cnt == 61'd0 && !r_ovf))
        else $error("no restart after last digest word");

endmodule
